[hdl/spsd_pkg.sv]
// ----------------------------------------------------------------------------
// spsd_pkg
// Shared types and constants of the speech pause split detector: widths,
// controller states, command and status bundles, register map.
// ----------------------------------------------------------------------------
package spsd_pkg;

    localparam int MAX_FRAME_SAMPLES = 1024;

    localparam int SAMPLE_W = 16;
    localparam int MAG_W    = SAMPLE_W + 1;
    localparam int SQ_W     = 31;
    localparam int LEN_W    = 11;
    localparam int SUM_W    = 41;
    localparam int RMS_W    = 23;
    localparam int ROOT_W   = 29;
    localparam int RAD_W    = 2 * ROOT_W;
    localparam int RREM_W   = ROOT_W + 3;
    localparam int CNT_W    = 16;
    localparam int MIN_W    = 8;
    localparam int RATIO_W  = 8;
    localparam int MARGIN_W = 15;
    localparam int RISE_W   = 16;
    localparam int PROD_W   = RMS_W + RISE_W;
    localparam int RHS_W    = RMS_W + RATIO_W;
    localparam int CMP_W    = 32;
    localparam int OUT_W    = 48;
    localparam int ITER_W   = 6;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    localparam int DIV_STEPS  = SUM_W;
    localparam int ROOT_STEPS = ROOT_W;

    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_FRAME_SAMPLES);
    localparam logic [RMS_W-1:0] RMS_SAT = {RMS_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_SAT = {CNT_W{1'b1}};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ACCUM,
        ST_DIVIDE,
        ST_ROOT_LOAD,
        ST_ROOT,
        ST_RMS,
        ST_FLOOR_MUL,
        ST_FLOOR_UPD,
        ST_QUIET_MUL,
        ST_OUTPUT
    } state_t;

    typedef struct packed {
        logic capture;
        logic square;
        logic accum;
        logic div_step;
        logic root_load;
        logic root_step;
        logic rms_load;
        logic floor_mul;
        logic floor_upd;
        logic quiet_mul;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic last_sample;
        logic out_free;
    } status_t;

    typedef struct packed {
        logic [LEN_W-1:0]    frame_samples;
        logic [CNT_W-1:0]    soft_limit;
        logic [CNT_W-1:0]    hard_limit;
        logic [MIN_W-1:0]    pause_frames;
        logic [RATIO_W-1:0]  floor_ratio_q4;
        logic [MARGIN_W-1:0] rms_margin;
        logic [RISE_W-1:0]   floor_rise_q16;
    } cfg_t;

    typedef enum logic [2:0] {
        REG_FRAME_SAMPLES,
        REG_SPLIT_AFTER,
        REG_SPLIT_FORCE,
        REG_SILENCE_MIN,
        REG_FLOOR_RATIO,
        REG_RMS_MARGIN,
        REG_FLOOR_RISE
    } reg_idx_t;

endpackage

[hdl/spsd_ctrl.sv]
// ----------------------------------------------------------------------------
// spsd_ctrl
// Sequencer: walks each sample through square and accumulate, and each frame
// end through divide, square root, floor update and result load.
// ----------------------------------------------------------------------------
module spsd_ctrl import spsd_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t             state_reg, state_next;
    logic [ITER_W-1:0]  iter_reg, iter_next;
    logic               div_end;
    logic               root_end;

    assign div_end  = (iter_reg == ITER_W'(DIV_STEPS - 1));
    assign root_end = (iter_reg == ITER_W'(ROOT_STEPS - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            iter_reg  <= '0;
        end else begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
        end
    end

    // step counter for the two iterative units
    always_comb begin
        if ((state_reg == ST_DIVIDE && !div_end) || (state_reg == ST_ROOT && !root_end)) begin
            iter_next = iter_reg + 1'b1;
        end else begin
            iter_next = '0;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (s_tvalid) state_next = ST_SQUARE;
            ST_SQUARE:    state_next = ST_ACCUM;
            ST_ACCUM:     state_next = status.last_sample ? ST_DIVIDE : ST_IDLE;
            ST_DIVIDE:    if (div_end) state_next = ST_ROOT_LOAD;
            ST_ROOT_LOAD: state_next = ST_ROOT;
            ST_ROOT:      if (root_end) state_next = ST_RMS;
            ST_RMS:       state_next = ST_FLOOR_MUL;
            ST_FLOOR_MUL: state_next = ST_FLOOR_UPD;
            ST_FLOOR_UPD: state_next = ST_QUIET_MUL;
            ST_QUIET_MUL: state_next = ST_OUTPUT;
            ST_OUTPUT:    if (status.out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_SQUARE:    cmd.square    = 1'b1;
            ST_ACCUM:     cmd.accum     = 1'b1;
            ST_DIVIDE:    cmd.div_step  = 1'b1;
            ST_ROOT_LOAD: cmd.root_load = 1'b1;
            ST_ROOT:      cmd.root_step = 1'b1;
            ST_RMS:       cmd.rms_load  = 1'b1;
            ST_FLOOR_MUL: cmd.floor_mul = 1'b1;
            ST_FLOOR_UPD: cmd.floor_upd = 1'b1;
            ST_QUIET_MUL: cmd.quiet_mul = 1'b1;
            ST_OUTPUT:    cmd.out_load  = status.out_free;
            default:      cmd = '0;
        endcase
    end

endmodule

[hdl/spsd_dp.sv]
// ----------------------------------------------------------------------------
// spsd_dp
// Datapath: square and sum, bit-serial divider, two-bit-per-step square root,
// noise floor tracker, quiet test, frame counters and result register.
// ----------------------------------------------------------------------------
module spsd_dp import spsd_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  cmd_t                cmd,
    output status_t             status,
    input  cfg_t                cfg,
    input  logic [SAMPLE_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OUT_W-1:0]    m_tdata
);

    logic [MAG_W-1:0]    mag_reg;
    logic [SQ_W-1:0]     sq_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [LEN_W-1:0]    index_reg;
    logic [SUM_W-1:0]    dvd_reg;
    logic [LEN_W-1:0]    rem_reg;
    logic [RAD_W-1:0]    rad_reg;
    logic [RREM_W-1:0]   rrem_reg;
    logic [ROOT_W-1:0]   root_reg;
    logic [RMS_W-1:0]    rms_reg;
    logic [RMS_W-1:0]    noise_reg;
    logic                known_reg;
    logic                take_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [RHS_W-1:0]    rhs_reg;
    logic [CNT_W-1:0]    quiet_cnt_reg;
    logic [CNT_W-1:0]    file_cnt_reg;
    logic                out_valid_reg;
    logic [OUT_W-1:0]    out_data_reg;

    logic signed [MAG_W-1:0] sample_x;
    logic [MAG_W-1:0]    mag;
    logic [LEN_W-1:0]    len;
    logic                last;
    logic [SUM_W-1:0]    sum_add;
    logic [LEN_W:0]      div_trial;
    logic                div_ge;
    logic [LEN_W-1:0]    rem_next;
    logic [RREM_W-1:0]   root_cur;
    logic [RREM_W-1:0]   root_trial;
    logic                root_ge;
    logic [RMS_W:0]      floor_sum;
    logic [CMP_W-1:0]    rhs;
    logic [CMP_W-1:0]    lhs;
    logic                quiet;
    logic [CNT_W-1:0]    quiet_cnt_next;
    logic [CNT_W-1:0]    file_cnt_next;
    logic                split;

    // sample magnitude, -32768 maps to 32768
    assign sample_x = {s_tdata[SAMPLE_W-1], s_tdata};
    assign mag      = s_tdata[SAMPLE_W-1] ? MAG_W'(-sample_x) : MAG_W'(sample_x);

    // effective frame length
    always_comb begin
        if (cfg.frame_samples == '0) begin
            len = LEN_W'(1);
        end else if (cfg.frame_samples > LEN_MAX) begin
            len = LEN_MAX;
        end else begin
            len = cfg.frame_samples;
        end
    end

    assign last    = ({1'b0, index_reg} + 1'b1) >= {1'b0, len};
    assign sum_add = sum_reg + SUM_W'(sq_reg);

    // restoring divide step
    assign div_trial = {rem_reg, dvd_reg[SUM_W-1]};
    assign div_ge    = div_trial >= {1'b0, len};
    assign rem_next  = div_ge ? LEN_W'(div_trial - {1'b0, len}) : div_trial[LEN_W-1:0];

    // square root step, two radicand bits at a time
    assign root_cur   = {rrem_reg[RREM_W-3:0], rad_reg[RAD_W-1 -: 2]};
    assign root_trial = RREM_W'({root_reg, 2'b01});
    assign root_ge    = root_cur >= root_trial;

    assign floor_sum = {1'b0, noise_reg} + (RMS_W + 1)'(prod_reg[PROD_W-1:RISE_W]);

    // quiet test: rms*16 <= floor*ratio + margin*4096
    assign rhs   = CMP_W'(rhs_reg) + (CMP_W'(cfg.rms_margin) << 12);
    assign lhs   = CMP_W'({rms_reg, 4'b0000});
    assign quiet = lhs <= rhs;

    always_comb begin
        if (quiet) begin
            quiet_cnt_next = (quiet_cnt_reg == CNT_SAT) ? quiet_cnt_reg : quiet_cnt_reg + 1'b1;
        end else begin
            quiet_cnt_next = '0;
        end
        file_cnt_next = (file_cnt_reg == CNT_SAT) ? file_cnt_reg : file_cnt_reg + 1'b1;
        split = (file_cnt_next >= cfg.hard_limit) ||
                ((file_cnt_next >= cfg.soft_limit) &&
                 (quiet_cnt_next >= CNT_W'(cfg.pause_frames)));
    end

    assign status.last_sample = last;
    assign status.out_free    = !out_valid_reg || m_tready;

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mag_reg <= mag;
        end
        if (cmd.square) begin
            sq_reg <= SQ_W'(mag_reg * mag_reg);
        end
        if (cmd.accum && last) begin
            dvd_reg <= sum_add;
            rem_reg <= '0;
        end else if (cmd.div_step) begin
            dvd_reg <= {dvd_reg[SUM_W-2:0], div_ge};
            rem_reg <= rem_next;
        end
        if (cmd.root_load) begin
            rad_reg  <= {1'b0, dvd_reg, 16'h0000};
            rrem_reg <= '0;
            root_reg <= '0;
        end else if (cmd.root_step) begin
            rad_reg  <= rad_reg << 2;
            rrem_reg <= root_ge ? root_cur - root_trial : root_cur;
            root_reg <= {root_reg[ROOT_W-2:0], root_ge};
        end
        if (cmd.rms_load) begin
            rms_reg <= (root_reg > ROOT_W'(RMS_SAT)) ? RMS_SAT : root_reg[RMS_W-1:0];
        end
        if (cmd.floor_mul) begin
            take_reg <= !known_reg || (rms_reg < noise_reg);
            prod_reg <= PROD_W'((rms_reg - noise_reg) * cfg.floor_rise_q16);
        end
        if (cmd.quiet_mul) begin
            rhs_reg <= RHS_W'(noise_reg * cfg.floor_ratio_q4);
        end
        if (cmd.out_load) begin
            out_data_reg <= {noise_reg, rms_reg, quiet, split};
        end
    end

    // frame state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg       <= '0;
            index_reg     <= '0;
            noise_reg     <= '0;
            known_reg     <= 1'b0;
            quiet_cnt_reg <= '0;
            file_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.accum) begin
                if (last) begin
                    sum_reg   <= '0;
                    index_reg <= '0;
                end else begin
                    sum_reg   <= sum_add;
                    index_reg <= index_reg + 1'b1;
                end
            end
            if (cmd.floor_upd) begin
                known_reg <= 1'b1;
                if (take_reg) begin
                    noise_reg <= rms_reg;
                end else begin
                    noise_reg <= floor_sum[RMS_W] ? RMS_SAT : floor_sum[RMS_W-1:0];
                end
            end
            if (cmd.out_load) begin
                quiet_cnt_reg <= split ? '0 : quiet_cnt_next;
                file_cnt_reg  <= split ? '0 : file_cnt_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

[hdl/speech_pause_split_detector_core.sv]
// ----------------------------------------------------------------------------
// speech_pause_split_detector_core
// Frame energy, noise floor tracking and file split decision for a mono
// 16-bit audio stream, with an APB register port.
// ----------------------------------------------------------------------------
// Each sample passes through capture, square and accumulate. The last sample
// of a frame adds the frame-end work: a bit-serial divide of the 41-bit square
// sum by the frame length, a root load, a square root that retires two radicand
// bits a cycle, the rms clamp, then floor update multiply, floor write,
// threshold multiply and the result load.
// The result register lets the next frame start while a result waits; the
// block only holds off at the next frame end if that result is still not
// taken. One result transfer leaves per frame, none for mid-frame samples.
// Registers are to be written only while the block is idle; it does not check.
module speech_pause_split_detector_core import spsd_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    // sample input
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [15:0]         s_tdata,   // [15:0] sample
    // frame result
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [47:0]         m_tdata,   // [0] split_now, [1] quiet_frame,
                                           // [24:2] rms_level, [47:25] floor_level
    // register port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready
);

    cfg_t     cfg_reg;
    cmd_t     cmd;
    status_t  status;
    reg_idx_t reg_idx;
    logic     cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    // register writes, codes past the last register are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_samples  <= LEN_W'(960);
            cfg_reg.soft_limit     <= CNT_W'(30000);
            cfg_reg.hard_limit     <= CNT_W'(35000);
            cfg_reg.pause_frames   <= MIN_W'(10);
            cfg_reg.floor_ratio_q4 <= RATIO_W'(32);
            cfg_reg.rms_margin     <= MARGIN_W'(40);
            cfg_reg.floor_rise_q16 <= RISE_W'(66);
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_FRAME_SAMPLES: cfg_reg.frame_samples  <= pwdata[LEN_W-1:0];
                REG_SPLIT_AFTER:   cfg_reg.soft_limit     <= pwdata[CNT_W-1:0];
                REG_SPLIT_FORCE:   cfg_reg.hard_limit     <= pwdata[CNT_W-1:0];
                REG_SILENCE_MIN:   cfg_reg.pause_frames   <= pwdata[MIN_W-1:0];
                REG_FLOOR_RATIO:   cfg_reg.floor_ratio_q4 <= pwdata[RATIO_W-1:0];
                REG_RMS_MARGIN:    cfg_reg.rms_margin     <= pwdata[MARGIN_W-1:0];
                REG_FLOOR_RISE:    cfg_reg.floor_rise_q16 <= pwdata[RISE_W-1:0];
                default: ;
            endcase
        end
    end

    // register read-back
    always_comb begin
        unique case (reg_idx)
            REG_FRAME_SAMPLES: prdata = DATA_W'(cfg_reg.frame_samples);
            REG_SPLIT_AFTER:   prdata = DATA_W'(cfg_reg.soft_limit);
            REG_SPLIT_FORCE:   prdata = DATA_W'(cfg_reg.hard_limit);
            REG_SILENCE_MIN:   prdata = DATA_W'(cfg_reg.pause_frames);
            REG_FLOOR_RATIO:   prdata = DATA_W'(cfg_reg.floor_ratio_q4);
            REG_RMS_MARGIN:    prdata = DATA_W'(cfg_reg.rms_margin);
            REG_FLOOR_RISE:    prdata = DATA_W'(cfg_reg.floor_rise_q16);
            default:           prdata = '0;
        endcase
    end

    // sequencer
    spsd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // arithmetic and frame state
    spsd_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .cfg      (cfg_reg),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // a sample transfer is always followed by a busy state with s_tready low
    a_busy_after_sample: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("sample accepted on consecutive cycles");

    // a result only appears through a result load
    a_result_from_load: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(cmd.out_load))
        else $error("result valid without a result load");

    // a result load never overwrites a result still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !m_tvalid || m_tready)
        else $error("result register overwritten before transfer");

endmodule

[tb/tb_speech_pause_split_detector_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_speech_pause_split_detector_core
// Self-checking bench for the pause split detector: drives sample transfers
// with random gaps, stalls the result side at random and once for a long
// stretch, programs the registers over APB between phases, and checks every
// frame result against a bit-true software tracker of the frame energy, noise
// floor and split counters.
// ----------------------------------------------------------------------------
module tb_speech_pause_split_detector_core;
    import spsd_pkg::*;

    // packed frame result, msb first as declared
    typedef struct packed {
        logic             split_now;
        logic             quiet_frame;
        logic [RMS_W-1:0] rms_level;
        logic [RMS_W-1:0] floor_level;
    } frame_report_t;

    // sample classes used to shape frames
    typedef enum int {
        CLS_HUSH,
        CLS_SOFT,
        CLS_ANY,
        CLS_RAIL
    } sample_class_t;

    localparam int SETTLE_CYCLES = 200;   // well above the time the frame-end work takes
    localparam int HOLD_CYCLES   = 3000;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [15:0]       s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [47:0]       m_tdata;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // traffic shaping knobs
    bit idle_on  = 1'b1;   // sender leaves gaps
    bit stall_on = 1'b1;   // receiver drops tready at random
    int hold_cycles = 0;   // long receiver hold-off, counted down by the receiver

    int mismatch_count = 0;
    frame_report_t reports_due[$];

    // tracker copy of the register file
    logic [LEN_W-1:0]    trk_len;
    logic [CNT_W-1:0]    trk_after;
    logic [CNT_W-1:0]    trk_force;
    logic [MIN_W-1:0]    trk_silmin;
    logic [RATIO_W-1:0]  trk_ratio;
    logic [MARGIN_W-1:0] trk_margin;
    logic [RISE_W-1:0]   trk_rise;

    // tracker copy of the frame and file state
    logic [SUM_W-1:0]    energy_acc;
    logic [LEN_W-1:0]    pos_in_frame;
    logic [RMS_W-1:0]    floor_now;
    logic                floor_set;
    logic [CNT_W-1:0]    hush_streak;
    logic [CNT_W-1:0]    file_frame_cnt;

    speech_pause_split_detector_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [15:0] sample
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // [0] split_now, [1] quiet_frame,
                                // [24:2] rms_level, [47:25] floor_level
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // hard stop in case the block hangs
    initial begin
        #20_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------------
    // tracker
    // ------------------------------------------------------------------------

    // frame length as the block uses it: zero reads as one, capped at the max
    function automatic longint unsigned frame_len_eff();
        if (trk_len == 0)
            return 1;
        if (trk_len > MAX_FRAME_SAMPLES)
            return MAX_FRAME_SAMPLES;
        return trk_len;
    endfunction

    // floor of the square root, built one result bit at a time from the top
    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned r;
        longint unsigned c;
        r = 0;
        for (int b = 24; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (c * c <= v)
                r = c;
        end
        return r;
    endfunction

    task automatic clear_tracker();
        trk_len        = LEN_W'(960);
        trk_after      = CNT_W'(30000);
        trk_force      = CNT_W'(35000);
        trk_silmin     = MIN_W'(10);
        trk_ratio      = RATIO_W'(32);
        trk_margin     = MARGIN_W'(40);
        trk_rise       = RISE_W'(66);
        energy_acc     = '0;
        pos_in_frame   = '0;
        floor_now      = '0;
        floor_set      = 1'b0;
        hush_streak    = '0;
        file_frame_cnt = '0;
    endtask

    // advance the tracker by one accepted sample, queue a report on frame end
    task automatic track_sample(input logic [15:0] raw);
        int              sv;
        longint unsigned mag;
        longint unsigned len;
        longint unsigned acc;
        longint unsigned rms;
        longint unsigned inc;
        longint unsigned nf;
        longint unsigned lhs;
        longint unsigned rhs;
        logic            quiet_b;
        logic            split_b;
        frame_report_t   rep;

        sv  = $signed(raw);
        mag = (sv < 0) ? -sv : sv;
        len = frame_len_eff();
        energy_acc = energy_acc + SUM_W'(mag * mag);
        if (pos_in_frame + 64'd1 < len) begin
            // mid-frame sample, nothing comes out
            pos_in_frame = pos_in_frame + 1'b1;
            return;
        end

        acc = energy_acc;
        rms = root_floor((acc / len) << 16);
        if (rms > RMS_SAT)
            rms = RMS_SAT;   // full-scale negative frame overflows the format
        energy_acc   = '0;
        pos_in_frame = '0;

        // floor drops at once, rises by a truncated fraction
        if (!floor_set || rms < floor_now) begin
            floor_now = RMS_W'(rms);
            floor_set = 1'b1;
        end else begin
            inc = ((rms - floor_now) * trk_rise) >> 16;
            nf  = floor_now + inc;
            if (nf > RMS_SAT)
                nf = RMS_SAT;
            floor_now = RMS_W'(nf);
        end

        // exact threshold compare, scaled by 16 on both sides
        lhs = rms * 16;
        rhs = longint'(floor_now) * trk_ratio + longint'(trk_margin) * 4096;
        quiet_b = (lhs <= rhs);

        if (quiet_b) begin
            if (hush_streak != CNT_SAT)
                hush_streak = hush_streak + 1'b1;
        end else begin
            hush_streak = '0;
        end
        if (file_frame_cnt != CNT_SAT)
            file_frame_cnt = file_frame_cnt + 1'b1;

        split_b = 1'b0;
        if (file_frame_cnt >= trk_force)
            split_b = 1'b1;
        else if (file_frame_cnt >= trk_after && hush_streak >= trk_silmin)
            split_b = 1'b1;
        if (split_b) begin
            file_frame_cnt = '0;
            hush_streak    = '0;
        end

        rep.split_now   = split_b;
        rep.quiet_frame = quiet_b;
        rep.rms_level   = RMS_W'(rms);
        rep.floor_level = floor_now;
        reports_due.push_back(rep);
    endtask

    // ------------------------------------------------------------------------
    // result side: random tready, long hold-off on request, compare on transfer
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("mismatch %0t: %s got %0h want %0h", $realtime, what, got, want);
    endtask

    always @(posedge aclk) begin
        frame_report_t got;
        frame_report_t want;
        if (hold_cycles > 0) begin
            hold_cycles = hold_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= !stall_on || ($urandom_range(99) >= 16);
        end

        if (aresetn && m_tvalid && m_tready) begin
            got.split_now   = m_tdata[0];
            got.quiet_frame = m_tdata[1];
            got.rms_level   = m_tdata[24:2];
            got.floor_level = m_tdata[47:25];
            if (reports_due.size() == 0) begin
                report_mismatch("result with nothing due", m_tdata, 0);
            end else begin
                want = reports_due.pop_front();
                if (got.split_now !== want.split_now)
                    report_mismatch("split_now", got.split_now, want.split_now);
                if (got.quiet_frame !== want.quiet_frame)
                    report_mismatch("quiet_frame", got.quiet_frame, want.quiet_frame);
                if (got.rms_level !== want.rms_level)
                    report_mismatch("rms_level", got.rms_level, want.rms_level);
                if (got.floor_level !== want.floor_level)
                    report_mismatch("floor_level", got.floor_level, want.floor_level);
            end
        end
    end

    // ------------------------------------------------------------------------
    // sample side and register port
    // ------------------------------------------------------------------------

    // one sample transfer; called and returns on a rising edge
    task automatic send_sample(input logic [15:0] smp);
        while (idle_on && $urandom_range(99) < 16) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        track_sample(smp);
    endtask

    // let every due result drain, then give the block time to go idle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (reports_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // setup then access; the register takes the value at the access edge
    task automatic apb_write(input reg_idx_t idx, input logic [DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(int'(idx) * 4);
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_FRAME_SAMPLES: trk_len    = val[LEN_W-1:0];
            REG_SPLIT_AFTER:   trk_after  = val[CNT_W-1:0];
            REG_SPLIT_FORCE:   trk_force  = val[CNT_W-1:0];
            REG_SILENCE_MIN:   trk_silmin = val[MIN_W-1:0];
            REG_FLOOR_RATIO:   trk_ratio  = val[RATIO_W-1:0];
            REG_RMS_MARGIN:    trk_margin = val[MARGIN_W-1:0];
            REG_FLOOR_RISE:    trk_rise   = val[RISE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input int len, input int after, input int force_lim,
                              input int silmin, input int ratio, input int margin,
                              input int rise);
        wait_idle();
        apb_write(REG_FRAME_SAMPLES, DATA_W'(len));
        apb_write(REG_SPLIT_AFTER,   DATA_W'(after));
        apb_write(REG_SPLIT_FORCE,   DATA_W'(force_lim));
        apb_write(REG_SILENCE_MIN,   DATA_W'(silmin));
        apb_write(REG_FLOOR_RATIO,   DATA_W'(ratio));
        apb_write(REG_RMS_MARGIN,    DATA_W'(margin));
        apb_write(REG_FLOOR_RISE,    DATA_W'(rise));
    endtask

    function automatic logic [15:0] pick_sample(input sample_class_t cls);
        int v;
        case (cls)
            CLS_HUSH: v = int'($urandom_range(0, 16)) - 8;
            CLS_SOFT: v = int'($urandom_range(0, 4000)) - 2000;
            CLS_RAIL: v = $urandom_range(1) ? -32768 : 32767;
            default:  v = $urandom;
        endcase
        return 16'(v);
    endfunction

    // fill up the current frame; a few samples stray from the frame's class
    task automatic send_frame(input sample_class_t cls, inout int sent);
        longint unsigned left;
        sample_class_t   c;
        left = frame_len_eff() - pos_in_frame;
        repeat (left) begin
            c = cls;
            if ($urandom_range(99) < 10)
                c = sample_class_t'($urandom_range(3));
            send_sample(pick_sample(c));
            sent++;
        end
    endtask

    function automatic sample_class_t pick_class();
        int r;
        r = $urandom_range(99);
        if (r < 45)
            return CLS_HUSH;
        if (r < 70)
            return CLS_SOFT;
        if (r < 92)
            return CLS_ANY;
        return CLS_RAIL;
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // one-sample frames at the edges of the sample range; the full-scale
    // negative frame saturates the rms
    task automatic test_sample_extremes();
        set_config(1, 2, 5, 1, 32, 40, 66);
        send_sample(16'h7fff);
        send_sample(16'h8000);
        send_sample(16'h0000);
        send_sample(16'h0001);
        send_sample(16'hffff);
        send_sample(16'h8000);
        send_sample(16'h5555);
    endtask

    // a length register of zero behaves as one sample per frame
    task automatic test_zero_length();
        set_config(0, 3, 4, 2, 16, 0, 32768);
        send_sample(16'h0100);
        send_sample(16'hff00);
        send_sample(16'h2aaa);
    endtask

    // shrinking the length mid-frame ends the frame on the next sample
    task automatic test_length_shrink();
        set_config(6, 10, 20, 2, 32, 5, 1000);
        repeat (4) send_sample(pick_sample(CLS_SOFT));
        wait_idle();
        apb_write(REG_FRAME_SAMPLES, DATA_W'(2));
        send_sample(pick_sample(CLS_ANY));
    endtask

    // zero limits: every frame splits
    task automatic test_zero_limits();
        set_config(1, 0, 0, 0, 16, 0, 0);
        send_sample(16'h1234);
        send_sample(16'hedcc);
        send_sample(16'h0003);
    endtask

    // tiny rise fraction: small upward steps leave the floor where it is
    task automatic test_floor_truncation();
        set_config(1, 100, 200, 3, 20, 1, 1);
        send_sample(16'd100);
        send_sample(16'd101);
        send_sample(16'd140);
        send_sample(16'd30000);
    endtask

    // random content under a series of register settings, extremes first
    task automatic test_random_phases();
        int sent;
        for (int p = 0; p < 9; p++) begin
            case (p)
                0: set_config(1, 1, 1, 1, 0, 0, 0);
                1: set_config(16, 65535, 65535, 255, 255, 32767, 65535);
                2: set_config(2047 - 1024 + 1, 1, 65535, 1, 255, 0, 65535);
                default: set_config(($urandom_range(9) == 0) ? 0 : $urandom_range(1, 12),
                                    $urandom_range(1, 12),
                                    $urandom_range(1) ? $urandom_range(1, 30) : 65535,
                                    $urandom_range(1, 6),
                                    $urandom_range(3) == 0 ? $urandom_range(0, 255)
                                                           : $urandom_range(16, 48),
                                    $urandom_range(3) == 0 ? $urandom_range(0, 32767)
                                                           : $urandom_range(0, 200),
                                    $urandom_range(0, 65535));
            endcase
            if (p == 2) begin
                // 1024 exactly is only programmed; the length goes to 4 before samples flow
                wait_idle();
                apb_write(REG_FRAME_SAMPLES, DATA_W'(4));
            end
            // one phase runs with no gaps and no stalls at all
            idle_on  = (p != 4);
            stall_on = (p != 4);
            sent = 0;
            while (sent < 90)
                send_frame(pick_class(), sent);
        end
        idle_on  = 1'b1;
        stall_on = 1'b1;
    endtask

    // receiver holds off long enough that the block backs up into its input
    task automatic test_output_backpressure();
        int sent;
        sent = 0;
        set_config(1, 3, 7, 2, 40, 10, 20000);
        idle_on = 1'b0;
        hold_cycles = HOLD_CYCLES;
        repeat (40) send_frame(pick_class(), sent);
        idle_on = 1'b1;
    endtask

    initial begin
        clear_tracker();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_sample_extremes();
        test_zero_length();
        test_length_shrink();
        test_zero_limits();
        test_floor_truncation();
        test_random_phases();
        test_output_backpressure();

        wait_idle();
        if (mismatch_count == 0 && reports_due.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
